// ===== rtl/core/iole_pkg.sv =====
// ----------------------------------------------------------------------------
// iole_pkg: indexed ordered list engine package
// Function and status codes, word types, cell modes and controller states.
// ----------------------------------------------------------------------------
package iole_pkg;

  // Operation selector
  typedef enum logic [2:0] {
    FN_INS_AT    = 3'd0,
    FN_INS_FIRST = 3'd1,
    FN_INS_LAST  = 3'd2,
    FN_READ      = 3'd3,
    FN_WRITE     = 3'd4,
    FN_DEL_AT    = 3'd5,
    FN_DEL_ALL   = 3'd6,
    FN_NOP       = 3'd7
  } func_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CM_HOLD    = 3'd0,
    CM_INSERT  = 3'd1,
    CM_WRITE   = 3'd2,
    CM_DELETE  = 3'd3,
    CM_MARK    = 3'd4,
    CM_COMPACT = 3'd5
  } cell_mode_e;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXEC    = 3'b010,
    S_COMPACT = 3'b100
  } state_e;

  // Input word
  typedef struct packed {
    func_e              func;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } req_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] read_value;
    status_e            status;
    logic [6:0]         list_count;
    logic [6:0]         removed_count;
  } rsp_t;

endpackage

// ===== rtl/core/iole_cell.sv =====
// ----------------------------------------------------------------------------
// iole_cell: one list entry
// Holds one entry and a keep flag; shifts toward either neighbor, loads a
// new value, marks itself for removal and drives its data on a read hit.
// ----------------------------------------------------------------------------
module iole_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7
) (
  input  logic                       clk_i,
  input  iole_pkg::cell_mode_e       mode_i,
  input  logic [CNT_W-1:0]           idx_i,
  input  logic [CNT_W-1:0]           at_i,
  input  logic [CNT_W-1:0]           cnt_i,
  input  logic [DATA_WIDTH-1:0]      val_i,
  input  logic [DATA_WIDTH-1:0]      left_data_i,
  input  logic [DATA_WIDTH-1:0]      right_data_i,
  input  logic                       right_keep_i,
  input  logic                       hole_i,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic                       keep_o,
  output logic                       hole_o,
  output logic [DATA_WIDTH-1:0]      rd_o
);
  import iole_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  keep_q, keep_d;
  logic                  hit, past;

  assign hit  = (idx_i == at_i);
  assign past = (idx_i > at_i);

  // a hole anywhere at or below this cell pulls the right neighbor in
  assign hole_o = hole_i | ~keep_q;

  // next entry value and keep flag
  always_comb begin
    data_d = data_q;
    keep_d = keep_q;
    unique case (mode_i)
      CM_INSERT: begin
        if (past) begin
          data_d = left_data_i;
        end else if (hit) begin
          data_d = val_i;
        end
      end
      CM_WRITE: begin
        if (hit) begin
          data_d = val_i;
        end
      end
      CM_DELETE: begin
        if (past || hit) begin
          data_d = right_data_i;
        end
      end
      CM_MARK: begin
        keep_d = (idx_i >= cnt_i) || (data_q != val_i);
      end
      CM_COMPACT: begin
        if (hole_o) begin
          data_d = right_data_i;
          keep_d = right_keep_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    keep_q <= keep_d;
  end

  assign data_o = data_q;
  assign keep_o = keep_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

// ===== rtl/core/indexed_ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_engine: ordered list with positional access
// Packed list of signed words held in a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_i and raise start; the word is taken at a clock
//   edge where start is high and busy is low. busy stays high while the
//   word is worked on.
//   Result channel: done_o is high for exactly one cycle with rsp_o valid.
//   The receiver cannot stall; every result must be taken in that cycle.
//   Insert, read, write, delete at position and the unused selector are
//   worked in the execute state, then the result is registered onto rsp_o
//   and done_o. Delete all equal marks matching cells in the execute state;
//   the compact state then closes the first hole along the chain once per
//   removed entry, and a last pass that finds no hole left registers the
//   result. A new word is not taken while one is worked on; busy drops in
//   the cycle done_o is shown, so the next word can be taken at its end.
//   Reset: the entry count clears to zero and the controller goes idle;
//   entry contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_ordered_list_engine #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  iole_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output iole_pkg::rsp_t rsp_o
);
  import iole_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  state_e                state_q, state_d;
  req_t                  req_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      removed_q, removed_d;
  logic                  done_q, done_d;
  rsp_t                  rsp_q, rsp_d;

  cell_mode_e            mode;
  logic [CMP_W-1:0]      pos_ext, cnt_ext, at_ext;
  logic [CNT_W-1:0]      at_cell;
  logic [DATA_WIDTH-1:0] val_dw;
  logic                  in_range, full;
  logic [DATA_WIDTH-1:0] rd_or;
  logic                  any_hole;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
  logic                  cell_keep [DEPTH];
  logic                  cell_hole [DEPTH];

  // operand decode
  assign pos_ext  = CMP_W'(req_q.position);
  assign cnt_ext  = CMP_W'(cnt_q);
  assign val_dw   = DATA_WIDTH'(req_q.item_value);
  assign in_range = (pos_ext < cnt_ext);
  assign full     = (cnt_q == CNT_W'(DEPTH));

  always_comb begin
    unique case (req_q.func)
      FN_INS_FIRST: at_ext = '0;
      FN_INS_LAST:  at_ext = cnt_ext;
      default:      at_ext = pos_ext;
    endcase
  end

  assign at_cell = at_ext[CNT_W-1:0];

  // chain of entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;
    logic                  right_keep, hole_in;

    if (g == 0) begin : g_first
      assign left_data = cell_data[0];
      assign hole_in   = 1'b0;
    end else begin : g_mid
      assign left_data = cell_data[g-1];
      assign hole_in   = cell_hole[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_data = cell_data[g];
      assign right_keep = 1'b1;
    end else begin : g_inner
      assign right_data = cell_data[g+1];
      assign right_keep = cell_keep[g+1];
    end

    iole_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i       (clk_i),
      .mode_i      (mode),
      .idx_i       (CNT_W'(g)),
      .at_i        (at_cell),
      .cnt_i       (cnt_q),
      .val_i       (val_dw),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .right_keep_i(right_keep),
      .hole_i      (hole_in),
      .data_o      (cell_data[g]),
      .keep_o      (cell_keep[g]),
      .hole_o      (cell_hole[g]),
      .rd_o        (cell_rd[g])
    );
  end

  assign any_hole = cell_hole[DEPTH-1];

  // read port: only the hit cell drives nonzero data
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // controller
  always_comb begin
    logic             emit;
    status_e          st;
    logic [DATA_WIDTH-1:0] rd_v;
    logic [CNT_W-1:0] rm_v;

    emit      = 1'b0;
    st        = ST_OK;
    rd_v      = '0;
    rm_v      = '0;
    state_d   = state_q;
    cnt_d     = cnt_q;
    removed_d = removed_q;
    mode      = CM_HOLD;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        emit = 1'b1;
        unique case (req_q.func)
          FN_INS_AT, FN_INS_FIRST, FN_INS_LAST: begin
            if (at_ext > cnt_ext) begin
              st = ST_RANGE;
            end else if (full) begin
              st = ST_FULL;
            end else begin
              mode  = CM_INSERT;
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
          FN_READ: begin
            if (in_range) begin
              rd_v = rd_or;
            end else begin
              st = ST_RANGE;
            end
          end
          FN_WRITE: begin
            if (in_range) begin
              mode = CM_WRITE;
            end else begin
              st = ST_RANGE;
            end
          end
          FN_DEL_AT: begin
            if (in_range) begin
              mode  = CM_DELETE;
              cnt_d = cnt_q - CNT_W'(1);
              rm_v  = CNT_W'(1);
            end else begin
              st = ST_RANGE;
            end
          end
          FN_DEL_ALL: begin
            emit      = 1'b0;
            mode      = CM_MARK;
            removed_d = '0;
          end
          FN_NOP: begin
            st = ST_OK;
          end
          default: begin
            st = ST_OK;
          end
        endcase
        state_d = emit ? S_IDLE : S_COMPACT;
      end
      S_COMPACT: begin
        // close the first hole each cycle until none is left
        if (any_hole) begin
          mode      = CM_COMPACT;
          cnt_d     = cnt_q - CNT_W'(1);
          removed_d = removed_q + CNT_W'(1);
        end else begin
          emit    = 1'b1;
          rm_v    = removed_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    done_d = emit;
    rsp_d  = rsp_q;
    if (emit) begin
      rsp_d.read_value    = 32'($signed(rd_v));
      rsp_d.status        = st;
      rsp_d.list_count    = 7'(cnt_d);
      rsp_d.removed_count = 7'(rm_v);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      removed_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      removed_q <= removed_d;
      done_q    <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start && (state_q == S_IDLE)) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
